// ===== rtl/qrs_pkg.sv =====
// Package for the quadratic root solver: outcome codes, root width and
// parameter defaults. No dependencies.
package qrs_pkg;

  localparam int COEF_WIDTH_DEF    = 16;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int ROOT_W            = 33;

  typedef enum logic [2:0] {
    OC_INFINITE = 3'd0,
    OC_NONE     = 3'd1,
    OC_LINEAR   = 3'd2,
    OC_DOUBLE   = 3'd3,
    OC_TWO      = 3'd4
  } outcome_t;

endpackage

// ===== rtl/quadratic_root_solver.sv =====
// Pipelined solver for a*x^2 + b*x + c = 0 with fixed-point roots.
// Depends on qrs_pkg.
//
// One coefficient set is accepted every clock cycle (busy stays low) and
// its result appears on out_strobe for one cycle. The pipeline holds a
// bit-serial square root, one root bit per stage, followed by restoring
// dividers that produce one quotient bit per stage. The receiver cannot
// stall, so every transaction leaves in accept order.
module quadratic_root_solver #(
  parameter int COEF_WIDTH    = qrs_pkg::COEF_WIDTH_DEF,
  parameter int FRACTION_BITS = qrs_pkg::FRACTION_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [COEF_WIDTH-1:0]        in_coef_a,
  input  logic signed [COEF_WIDTH-1:0]        in_coef_b,
  input  logic signed [COEF_WIDTH-1:0]        in_coef_c,
  output logic                                out_strobe,
  output qrs_pkg::outcome_t                   out_outcome,
  output logic signed [qrs_pkg::ROOT_W-1:0]   out_root_first,
  output logic signed [qrs_pkg::ROOT_W-1:0]   out_root_second
);
  import qrs_pkg::*;

  localparam int CW   = COEF_WIDTH;
  localparam int F    = FRACTION_BITS;
  localparam int DLW  = 2 * CW + 3;
  localparam int P    = CW + 1 + F;
  localparam int RW   = P + 3;
  localparam int NW   = CW + F + 2;
  localparam int DMW  = CW + 1;
  localparam int QW   = NW + 1;
  localparam int SW   = (QW > ROOT_W) ? QW : ROOT_W;

  typedef struct packed {
    outcome_t               code;
    logic signed [CW-1:0]   a;
    logic signed [CW-1:0]   b;
    logic signed [CW-1:0]   c;
  } side_t;

  typedef struct packed {
    outcome_t code;
    logic     neg1;
    logic     neg2;
  } dside_t;

  function automatic logic signed [ROOT_W-1:0] sat_root(input logic [NW-1:0] q,
                                                         input logic neg);
    logic signed [QW-1:0] v;
    logic signed [SW-1:0] e;
    logic signed [SW-1:0] hi;
    logic signed [SW-1:0] lo;
    v  = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    e  = SW'(v);
    hi = $signed({{(SW - ROOT_W + 1){1'b0}}, {(ROOT_W - 1){1'b1}}});
    lo = $signed({{(SW - ROOT_W + 1){1'b1}}, {(ROOT_W - 1){1'b0}}});
    if (e > hi) begin
      e = hi;
    end else if (e < lo) begin
      e = lo;
    end
    return e[ROOT_W-1:0];
  endfunction

  assign busy = 1'b0;

  // Input register.
  logic                 s1_v_r;
  logic signed [CW-1:0] s1_a_r, s1_b_r, s1_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= start && !busy;
    end
    s1_a_r <= in_coef_a;
    s1_b_r <= in_coef_b;
    s1_c_r <= in_coef_c;
  end

  // Products.
  logic                   s2_v_r;
  logic signed [2*CW-1:0] s2_bb_r, s2_ac_r;
  logic signed [CW-1:0]   s2_a_r, s2_b_r, s2_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r;
    end
    s2_bb_r <= s1_b_r * s1_b_r;
    s2_ac_r <= s1_a_r * s1_c_r;
    s2_a_r  <= s1_a_r;
    s2_b_r  <= s1_b_r;
    s2_c_r  <= s1_c_r;
  end

  // Discriminant and case selection feed the square root pipeline.
  logic signed [DLW-1:0] delta_nxt;
  outcome_t              code_nxt;

  always_comb begin
    delta_nxt = DLW'(s2_bb_r) - (DLW'(s2_ac_r) <<< 2);
    if (s2_a_r == '0) begin
      if (s2_b_r == '0) begin
        code_nxt = (s2_c_r == '0) ? OC_INFINITE : OC_NONE;
      end else begin
        code_nxt = OC_LINEAR;
      end
    end else if (delta_nxt < 0) begin
      code_nxt = OC_NONE;
    end else if (delta_nxt == '0) begin
      code_nxt = OC_DOUBLE;
    end else begin
      code_nxt = OC_TWO;
    end
  end

  logic          sq_v_r    [P+1];
  logic [2*P-1:0] sq_rad_r [P+1];
  logic [RW-1:0] sq_rem_r  [P+1];
  logic [P-1:0]  sq_root_r [P+1];
  side_t         sq_side_r [P+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r[0] <= 1'b0;
    end else begin
      sq_v_r[0] <= s2_v_r;
    end
    sq_rad_r[0]  <= {delta_nxt[2*CW+1:0], {(2 * F){1'b0}}};
    sq_rem_r[0]  <= '0;
    sq_root_r[0] <= '0;
    sq_side_r[0] <= '{code: code_nxt, a: s2_a_r, b: s2_b_r, c: s2_c_r};
  end

  for (genvar k = 0; k < P; k++) begin : g_sqrt
    logic [RW-1:0] rsh_nxt, trial_nxt, rem_nxt;
    logic          ge_nxt;

    always_comb begin
      rsh_nxt   = {sq_rem_r[k][RW-3:0], sq_rad_r[k][2*P-1 -: 2]};
      trial_nxt = {1'b0, sq_root_r[k], 2'b01};
      ge_nxt    = rsh_nxt >= trial_nxt;
      rem_nxt   = ge_nxt ? rsh_nxt - trial_nxt : rsh_nxt;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[k+1] <= 1'b0;
      end else begin
        sq_v_r[k+1] <= sq_v_r[k];
      end
      sq_rad_r[k+1]  <= sq_rad_r[k] << 2;
      sq_rem_r[k+1]  <= rem_nxt;
      sq_root_r[k+1] <= {sq_root_r[k][P-2:0], ge_nxt};
      sq_side_r[k+1] <= sq_side_r[k];
    end
  end

  // Signed numerators and denominator.
  logic signed [NW:0]  n1_nxt, n2_nxt, bx_nxt, cx_nxt, sx_nxt;
  logic signed [CW:0]  den_nxt;
  logic                pr_v_r;
  logic signed [NW:0]  pr_n1_r, pr_n2_r;
  logic signed [CW:0]  pr_den_r;
  outcome_t            pr_code_r;

  always_comb begin
    bx_nxt = (NW + 1)'(sq_side_r[P].b);
    cx_nxt = (NW + 1)'(sq_side_r[P].c);
    sx_nxt = $signed({2'b00, sq_root_r[P]});
    if (sq_side_r[P].code == OC_LINEAR) begin
      n1_nxt  = -(cx_nxt <<< F);
      n2_nxt  = '0;
      den_nxt = (CW + 1)'(sq_side_r[P].b);
    end else begin
      n1_nxt  = -(bx_nxt <<< F) + sx_nxt;
      n2_nxt  = -(bx_nxt <<< F) - sx_nxt;
      den_nxt = $signed({sq_side_r[P].a, 1'b0});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pr_v_r <= 1'b0;
    end else begin
      pr_v_r <= sq_v_r[P];
    end
    pr_n1_r   <= n1_nxt;
    pr_n2_r   <= n2_nxt;
    pr_den_r  <= den_nxt;
    pr_code_r <= sq_side_r[P].code;
  end

  // Restoring dividers on magnitudes, one quotient bit per stage.
  logic           dv_v_r    [NW+1];
  logic [NW-1:0]  dv_num1_r [NW+1];
  logic [NW-1:0]  dv_num2_r [NW+1];
  logic [DMW-1:0] dv_rem1_r [NW+1];
  logic [DMW-1:0] dv_rem2_r [NW+1];
  logic [DMW-1:0] dv_den_r  [NW+1];
  dside_t         dv_side_r [NW+1];

  logic [NW:0] m1_nxt, m2_nxt;
  logic [CW:0] dm_nxt;

  always_comb begin
    m1_nxt = pr_n1_r[NW] ? -pr_n1_r : pr_n1_r;
    m2_nxt = pr_n2_r[NW] ? -pr_n2_r : pr_n2_r;
    dm_nxt = pr_den_r[CW] ? -pr_den_r : pr_den_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else begin
      dv_v_r[0] <= pr_v_r;
    end
    dv_num1_r[0] <= m1_nxt[NW-1:0];
    dv_num2_r[0] <= m2_nxt[NW-1:0];
    dv_rem1_r[0] <= '0;
    dv_rem2_r[0] <= '0;
    dv_den_r[0]  <= dm_nxt;
    dv_side_r[0] <= '{code: pr_code_r,
                      neg1: pr_n1_r[NW] ^ pr_den_r[CW],
                      neg2: pr_n2_r[NW] ^ pr_den_r[CW]};
  end

  for (genvar j = 0; j < NW; j++) begin : g_div
    logic [DMW:0] rs1_nxt, rs2_nxt, dd_nxt, r1_nxt, r2_nxt;
    logic         ge1_nxt, ge2_nxt;

    always_comb begin
      dd_nxt  = {1'b0, dv_den_r[j]};
      rs1_nxt = {dv_rem1_r[j], dv_num1_r[j][NW-1]};
      rs2_nxt = {dv_rem2_r[j], dv_num2_r[j][NW-1]};
      ge1_nxt = rs1_nxt >= dd_nxt;
      ge2_nxt = rs2_nxt >= dd_nxt;
      r1_nxt  = ge1_nxt ? rs1_nxt - dd_nxt : rs1_nxt;
      r2_nxt  = ge2_nxt ? rs2_nxt - dd_nxt : rs2_nxt;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[j+1] <= 1'b0;
      end else begin
        dv_v_r[j+1] <= dv_v_r[j];
      end
      dv_num1_r[j+1] <= {dv_num1_r[j][NW-2:0], ge1_nxt};
      dv_num2_r[j+1] <= {dv_num2_r[j][NW-2:0], ge2_nxt};
      dv_rem1_r[j+1] <= r1_nxt[DMW-1:0];
      dv_rem2_r[j+1] <= r2_nxt[DMW-1:0];
      dv_den_r[j+1]  <= dv_den_r[j];
      dv_side_r[j+1] <= dv_side_r[j];
    end
  end

  // Output register.
  logic                     out_strobe_r;
  outcome_t                 out_outcome_r;
  logic signed [ROOT_W-1:0] out_root1_r, out_root2_r;
  logic signed [ROOT_W-1:0] root1_nxt, root2_nxt;

  always_comb begin
    root1_nxt = '0;
    root2_nxt = '0;
    unique case (dv_side_r[NW].code)
      OC_LINEAR: begin
        root1_nxt = sat_root(dv_num1_r[NW], dv_side_r[NW].neg1);
      end
      OC_DOUBLE, OC_TWO: begin
        root1_nxt = sat_root(dv_num1_r[NW], dv_side_r[NW].neg1);
        root2_nxt = sat_root(dv_num2_r[NW], dv_side_r[NW].neg2);
      end
      default: begin
        root1_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= dv_v_r[NW];
    end
    out_outcome_r <= dv_side_r[NW].code;
    out_root1_r   <= root1_nxt;
    out_root2_r   <= root2_nxt;
  end

  assign out_strobe      = out_strobe_r;
  assign out_outcome     = out_outcome_r;
  assign out_root_first  = out_root1_r;
  assign out_root_second = out_root2_r;

`ifndef SYNTHESIS
  a_unused_first_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_outcome == OC_INFINITE || out_outcome == OC_NONE)
    |-> out_root_first == '0)
    else $error("first root not zero for a transaction without roots");

  a_unused_second_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_outcome == OC_INFINITE || out_outcome == OC_NONE ||
                   out_outcome == OC_LINEAR)
    |-> out_root_second == '0)
    else $error("second root not zero for a transaction with at most one root");

  a_double_equal: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_outcome == OC_DOUBLE |-> out_root_first == out_root_second)
    else $error("double root differs between fields");
`endif

endmodule
